// ===== design/qvr_pkg.sv =====
package qvr_pkg;

    // field widths
    localparam int VECTOR_WIDTH = 24;
    localparam int QUAT_WIDTH   = 16;

    // fraction shift of the final product: Q1.14 squared gives 28 bits
    localparam int FRAC_SHIFT = 2 * (QUAT_WIDTH - 2);

    // derived datapath widths
    localparam int QPROD_W = 2 * QUAT_WIDTH;
    localparam int MAT_W   = 2 * QUAT_WIDTH + 2;
    localparam int PROD_W  = MAT_W + VECTOR_WIDTH;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SHR_W   = ACC_W - FRAC_SHIFT;

    // configuration port
    localparam int NUM_REGS   = 4;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int PADDR_W    = REG_IDX_W + 2;
    localparam int PDATA_W    = 32;

    // cycles for the rotation matrix to follow a register write
    localparam int SETTLE_CYCLES = 2;
    localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_QUAT_W,
        REG_QUAT_X,
        REG_QUAT_Y,
        REG_QUAT_Z
    } qvr_reg_idx_t;

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE =
        QUAT_WIDTH'(1) << (QUAT_WIDTH - 2);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

    localparam logic signed [VECTOR_WIDTH-1:0] VEC_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
    localparam logic signed [VECTOR_WIDTH-1:0] VEC_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

endpackage

// ===== design/qvr_if.sv =====
interface qvr_point_if;
    import qvr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [VECTOR_WIDTH-1:0] point_x;
    logic signed [VECTOR_WIDTH-1:0] point_y;
    logic signed [VECTOR_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface qvr_result_if;
    import qvr_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [VECTOR_WIDTH-1:0] rotated_x;
    logic signed [VECTOR_WIDTH-1:0] rotated_y;
    logic signed [VECTOR_WIDTH-1:0] rotated_z;
    logic                           saturated;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    output saturated, input ready);
    modport sink (input valid, input rotated_x, input rotated_y, input rotated_z,
                  input saturated, output ready);
endinterface

// ===== design/quaternion_vector_rotate_core.sv =====
// channel   direction  payload                                        handshake
// point     in         point_x, point_y, point_z (24b signed)         valid/ready
// result    out        rotated_x/y/z (24b signed), saturated          valid/ready
// apb       in/out     quat_w, quat_x, quat_y, quat_z (16b Q1.14)      psel/penable
//
// one request per cycle while point.ready is high; a taken request passes the input register pt1_reg,
// the 34x24 multiplier stage, the adder stage and the clamping output stage, in that order
// the rotation matrix is rebuilt from the registers through the product and matrix registers;
// point.ready stays low during a register write and, after reset or a write, until hold_reg counts down
// a stalled result holds in the output stage; the stages behind it keep filling

module quaternion_vector_rotate_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qvr_pkg::PADDR_W-1:0] paddr,
    input  logic [qvr_pkg::PDATA_W-1:0] pwdata,
    output logic [qvr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    qvr_point_if.sink                   point,
    qvr_result_if.source                result
);
    import qvr_pkg::*;

    // configuration registers
    logic signed [QUAT_WIDTH-1:0] quat_reg [NUM_REGS];
    logic [SETTLE_W-1:0]          hold_reg;
    logic [SETTLE_W-1:0]          hold_next;
    logic                         cfg_wr;
    qvr_reg_idx_t                 cfg_idx;

    // quaternion products and rotation matrix
    logic signed [QPROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [MAT_W-1:0]   mat_reg [3][3];
    logic signed [MAT_W-1:0]   mat_next [3][3];

    // item pipeline
    logic                           v1_reg, v2_reg, v3_reg, v4_reg;
    logic                           rdy1, rdy2, rdy3, rdy4;
    logic signed [VECTOR_WIDTH-1:0] pt1_reg [3];
    logic signed [PROD_W-1:0]       mul2_reg [3][3];
    logic signed [ACC_W-1:0]        acc3_reg [3];
    logic signed [ACC_W-1:0]        acc_next [3];
    logic signed [VECTOR_WIDTH-1:0] rot4_reg [3];
    logic signed [VECTOR_WIDTH-1:0] rot_next [3];
    logic                           sat4_reg;
    logic                           sat_next;
    logic signed [SHR_W-1:0]        shr [3];

    // apb access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = qvr_reg_idx_t'(paddr[PADDR_W-1:2]);
    assign prdata  = PDATA_W'(quat_reg[cfg_idx]);

    always_comb
    begin
        if (cfg_wr)
        begin
            hold_next = SETTLE_W'(SETTLE_CYCLES);
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - SETTLE_W'(1);
        end
        else
        begin
            hold_next = hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg[REG_QUAT_W] <= QUAT_ONE;
            quat_reg[REG_QUAT_X] <= '0;
            quat_reg[REG_QUAT_Y] <= '0;
            quat_reg[REG_QUAT_Z] <= '0;
            hold_reg             <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_wr)
            begin
                quat_reg[cfg_idx] <= pwdata[QUAT_WIDTH-1:0];
            end
            hold_reg <= hold_next;
        end
    end

    // quaternion products, one multiply per register
    always_ff @(posedge clk)
    begin
        ww_reg <= quat_reg[REG_QUAT_W] * quat_reg[REG_QUAT_W];
        xx_reg <= quat_reg[REG_QUAT_X] * quat_reg[REG_QUAT_X];
        yy_reg <= quat_reg[REG_QUAT_Y] * quat_reg[REG_QUAT_Y];
        zz_reg <= quat_reg[REG_QUAT_Z] * quat_reg[REG_QUAT_Z];
        xy_reg <= quat_reg[REG_QUAT_X] * quat_reg[REG_QUAT_Y];
        wz_reg <= quat_reg[REG_QUAT_W] * quat_reg[REG_QUAT_Z];
        xz_reg <= quat_reg[REG_QUAT_X] * quat_reg[REG_QUAT_Z];
        wy_reg <= quat_reg[REG_QUAT_W] * quat_reg[REG_QUAT_Y];
        yz_reg <= quat_reg[REG_QUAT_Y] * quat_reg[REG_QUAT_Z];
        wx_reg <= quat_reg[REG_QUAT_W] * quat_reg[REG_QUAT_X];
    end

    // rotation matrix from the component products, the matrix form of the two hamilton products
    always_comb
    begin
        mat_next[0][0] = MAT_W'(ww_reg) + MAT_W'(xx_reg) - MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next[1][1] = MAT_W'(ww_reg) - MAT_W'(xx_reg) + MAT_W'(yy_reg) - MAT_W'(zz_reg);
        mat_next[2][2] = MAT_W'(ww_reg) - MAT_W'(xx_reg) - MAT_W'(yy_reg) + MAT_W'(zz_reg);
        mat_next[0][1] = (MAT_W'(xy_reg) - MAT_W'(wz_reg)) <<< 1;
        mat_next[0][2] = (MAT_W'(xz_reg) + MAT_W'(wy_reg)) <<< 1;
        mat_next[1][0] = (MAT_W'(xy_reg) + MAT_W'(wz_reg)) <<< 1;
        mat_next[1][2] = (MAT_W'(yz_reg) - MAT_W'(wx_reg)) <<< 1;
        mat_next[2][0] = (MAT_W'(xz_reg) - MAT_W'(wy_reg)) <<< 1;
        mat_next[2][1] = (MAT_W'(yz_reg) + MAT_W'(wx_reg)) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    // stage ready chain
    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign point.ready = rdy1 && (hold_reg == '0) && !cfg_wr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= point.valid && point.ready;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // row sums with the rounding half folded in
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = ACC_W'(mul2_reg[i][0]) + ACC_W'(mul2_reg[i][1])
                        + ACC_W'(mul2_reg[i][2]) + ROUND_HALF;
        end
    end

    // shift down and clamp
    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            shr[i] = $signed(acc3_reg[i][ACC_W-1:FRAC_SHIFT]);
            if (shr[i] > SHR_W'(VEC_MAX))
            begin
                rot_next[i] = VEC_MAX;
                sat_next    = 1'b1;
            end
            else if (shr[i] < SHR_W'(VEC_MIN))
            begin
                rot_next[i] = VEC_MIN;
                sat_next    = 1'b1;
            end
            else
            begin
                rot_next[i] = shr[i][VECTOR_WIDTH-1:0];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && point.valid && point.ready)
        begin
            pt1_reg[0] <= point.point_x;
            pt1_reg[1] <= point.point_y;
            pt1_reg[2] <= point.point_z;
        end
        if (rdy2 && v1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    mul2_reg[i][j] <= PROD_W'(mat_reg[i][j]) * PROD_W'(pt1_reg[j]);
                end
            end
        end
        if (rdy3 && v2_reg)
        begin
            acc3_reg <= acc_next;
        end
        if (rdy4 && v3_reg)
        begin
            rot4_reg <= rot_next;
            sat4_reg <= sat_next;
        end
    end

    assign result.valid     = v4_reg;
    assign result.rotated_x = rot4_reg[0];
    assign result.rotated_y = rot4_reg[1];
    assign result.rotated_z = rot4_reg[2];
    assign result.saturated = sat4_reg;

`ifndef SYNTHESIS
    // a register write keeps new points out while the matrix rebuilds
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !point.ready)
        else $error("point accepted right after a register write");

    // an accepted point enters the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> v1_reg)
        else $error("accepted point lost at the input stage");

    // a full adder stage moves to the output when the output can take it
    a_sum_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> result.valid)
        else $error("sum stage result did not reach the output");

    // the flag only comes with a clamped component
    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |->
            (result.rotated_x == VEC_MAX || result.rotated_x == VEC_MIN ||
             result.rotated_y == VEC_MAX || result.rotated_y == VEC_MIN ||
             result.rotated_z == VEC_MAX || result.rotated_z == VEC_MIN))
        else $error("saturated flag without a clamped component");
`endif

endmodule
